// ===== hdl/pid_pkg.sv =====
// Shared types and constants for the packet intrusion detector.
// Used by pid_front, pid_back and the top module; depends on nothing.
`timescale 1ns / 1ps
package pid_pkg;

  localparam int SOURCE_ENTRIES_DEF   = 64;
  localparam int PORTS_PER_SOURCE_DEF = 64;
  localparam int SCAN_WINDOW_SEC_DEF  = 60;

  localparam int NP_W = 9;  // port count, up to 511

  localparam logic [7:0] IP_TCP    = 8'd6;
  localparam logic [7:0] IP_UDP    = 8'd17;
  localparam logic [7:0] IP_ICMP   = 8'd1;
  localparam logic [5:0] FLAG_FIN  = 6'h01;
  localparam logic [5:0] FLAG_SYN  = 6'h02;
  localparam logic [5:0] FLAGS_ALL = 6'h3F;

  localparam logic [2:0] CFG_SYN_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_SCAN_LIMIT = 3'd1;
  localparam logic [2:0] CFG_SIZE_MIN   = 3'd2;
  localparam logic [2:0] CFG_SIZE_MAX   = 3'd3;
  localparam logic [2:0] CFG_ICMP_LIMIT = 3'd4;
  localparam logic [2:0] CFG_UDP_LIMIT  = 3'd5;

  localparam logic [2:0] ANOM_NONE    = 3'd0;
  localparam logic [2:0] ANOM_SMALL   = 3'd1;
  localparam logic [2:0] ANOM_LARGE   = 3'd2;
  localparam logic [2:0] ANOM_SYN_FIN = 3'd3;
  localparam logic [2:0] ANOM_ALL     = 3'd4;
  localparam logic [2:0] ANOM_NO_FLAG = 3'd5;

  localparam logic [1:0] SEL_SYN  = 2'd0;
  localparam logic [1:0] SEL_ICMP = 2'd1;
  localparam logic [1:0] SEL_UDP  = 2'd2;

  typedef enum logic [2:0] {
    B_IDLE, B_SWEEP, B_UPDATE, B_PORTS, B_WRITE, B_DONE
  } back_state_t;

  typedef struct packed {
    logic [15:0] syn_limit;
    logic [15:0] scan_limit;
    logic [15:0] size_min;
    logic [15:0] size_max;
    logic [15:0] icmp_limit;
    logic [15:0] udp_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] src;
    logic [15:0] port;
    logic [31:0] now;
    logic [2:0]  kind;
    logic        need_rate;
    logic [1:0]  sel;
    logic        need_scan;
  } cmd_t;

  typedef struct packed {
    logic       syn;
    logic       scan;
    logic [2:0] kind;
    logic       icmp;
    logic       udp;
    logic       any;
  } result_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] start;
    logic [15:0] count;
  } rate_ent_t;

  typedef struct packed {
    logic [31:0]     src;
    logic [31:0]     start;
    logic [NP_W-1:0] np;
  } scan_ent_t;

endpackage

// ===== hdl/pid_fifo.sv =====
// Two-entry queue of packed words, used between front and back and at the output.
// Depends on nothing.
`timescale 1ns / 1ps
module pid_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   cnt;
  logic         do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
    if (do_push) mem[wp] <= din;
  end
endmodule

// ===== hdl/pid_front.sv =====
// Front end: configuration registers and per-packet classification
// (anomaly kind, which tables the packet touches). Depends on pid_pkg.
`timescale 1ns / 1ps
module pid_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [7:0]         proto_num,
  input  logic [31:0]        source_addr,
  input  logic [15:0]        dest_port_num,
  input  logic [15:0]        byte_length,
  input  logic [5:0]         flag_bits,
  input  logic               has_tcp_hdr,
  input  logic [31:0]        stamp_sec,
  output pid_pkg::cmd_t      cmd,
  output pid_pkg::cfg_t      cfg
);
  logic is_tcp, is_udp, is_icmp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.syn_limit  <= 16'd100;
      cfg.scan_limit <= 16'd20;
      cfg.size_min   <= 16'd20;
      cfg.size_max   <= 16'd1500;
      cfg.icmp_limit <= 16'd50;
      cfg.udp_limit  <= 16'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pid_pkg::CFG_SYN_LIMIT:  cfg.syn_limit  <= cfg_data;
        pid_pkg::CFG_SCAN_LIMIT: cfg.scan_limit <= cfg_data;
        pid_pkg::CFG_SIZE_MIN:   cfg.size_min   <= cfg_data;
        pid_pkg::CFG_SIZE_MAX:   cfg.size_max   <= cfg_data;
        pid_pkg::CFG_ICMP_LIMIT: cfg.icmp_limit <= cfg_data;
        pid_pkg::CFG_UDP_LIMIT:  cfg.udp_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_tcp  = (proto_num == pid_pkg::IP_TCP);
  assign is_udp  = (proto_num == pid_pkg::IP_UDP);
  assign is_icmp = (proto_num == pid_pkg::IP_ICMP);

  always_comb begin
    cmd.src       = source_addr;
    cmd.port      = dest_port_num;
    cmd.now       = stamp_sec;
    cmd.need_scan = is_tcp || is_udp;
    cmd.need_rate = (is_tcp && ((flag_bits & pid_pkg::FLAG_SYN) != 6'd0)) || is_icmp || is_udp;
    priority if (is_icmp) cmd.sel = pid_pkg::SEL_ICMP;
    else if (is_udp)      cmd.sel = pid_pkg::SEL_UDP;
    else                  cmd.sel = pid_pkg::SEL_SYN;
    priority if (byte_length < cfg.size_min) cmd.kind = pid_pkg::ANOM_SMALL;
    else if (byte_length > cfg.size_max)     cmd.kind = pid_pkg::ANOM_LARGE;
    else if (is_tcp && has_tcp_hdr && ((flag_bits & pid_pkg::FLAG_SYN) != 6'd0)
             && ((flag_bits & pid_pkg::FLAG_FIN) != 6'd0))
      cmd.kind = pid_pkg::ANOM_SYN_FIN;
    else if (is_tcp && has_tcp_hdr && flag_bits == pid_pkg::FLAGS_ALL)
      cmd.kind = pid_pkg::ANOM_ALL;
    else if (is_tcp && has_tcp_hdr && flag_bits == 6'd0)
      cmd.kind = pid_pkg::ANOM_NO_FLAG;
    else
      cmd.kind = pid_pkg::ANOM_NONE;
  end
endmodule

// ===== hdl/pid_back.sv =====
// Back end: sweeps the source tables, updates rate and scan state, searches the
// port list and builds the result. Depends on pid_pkg.
`timescale 1ns / 1ps
module pid_back #(
  parameter int SOURCE_ENTRIES   = pid_pkg::SOURCE_ENTRIES_DEF,
  parameter int PORTS_PER_SOURCE = pid_pkg::PORTS_PER_SOURCE_DEF,
  parameter int SCAN_WINDOW_SEC  = pid_pkg::SCAN_WINDOW_SEC_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pid_pkg::cfg_t    cfg,
  input  pid_pkg::cmd_t    cmd_in,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  output pid_pkg::result_t res_out,
  input  logic             res_full,
  output logic             res_push
);
  localparam int N  = SOURCE_ENTRIES;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int PW = (PORTS_PER_SOURCE > 1) ? $clog2(PORTS_PER_SOURCE) : 1;
  localparam int NPW = pid_pkg::NP_W;
  localparam logic [NPW-1:0] P_MAX = NPW'(PORTS_PER_SOURCE);
  localparam logic [31:0] WIN = 32'(SCAN_WINDOW_SEC);

  pid_pkg::back_state_t state, state_next;

  pid_pkg::rate_ent_t rmem [3*(1<<IW)];
  pid_pkg::scan_ent_t smem [N];
  logic [15:0]        pmem [N*(1<<PW)];
  logic [N-1:0]       rvalid [3];
  logic [N-1:0]       svalid;

  pid_pkg::cmd_t      cur;
  pid_pkg::rate_ent_t r_rd, r_ent, r_base, r_new;
  pid_pkg::scan_ent_t s_rd, s_ent, s_base;
  logic [15:0]        p_rd;
  logic [IW:0]        cnt;
  logic               lag_v;
  logic [IW-1:0]      lag_idx;
  logic               r_found, r_free, s_found, s_free;
  logic [IW-1:0]      r_idx, r_fidx, s_idx, s_fidx, r_sel_idx, s_sel_idx;
  logic               s_ok;
  logic [IW-1:0]      s_w_idx;
  logic [31:0]        s_start;
  logic [NPW-1:0]     s_np, np_new;
  logic [NPW-1:0]     k, p_lag_k;
  logic               p_lag_v, p_found;
  logic               r_ok, s_ok_now, s_restart;
  logic [31:0]        s_diff;
  logic [15:0]        r_limit;
  pid_pkg::result_t   res;
  logic               sweep_last, ports_last, ports_go;

  always_comb begin
    res_out     = res;
    res_out.any = res.syn | res.scan | res.icmp | res.udp | (res.kind != pid_pkg::ANOM_NONE);
  end

  assign r_sel_idx = r_found ? r_idx : r_fidx;
  assign s_sel_idx = s_found ? s_idx : s_fidx;
  assign r_ok      = cur.need_rate && (r_found || r_free);
  assign s_ok_now  = cur.need_scan && (s_found || s_free);

  always_comb begin
    r_base = r_found ? r_ent : '{src: cur.src, start: cur.now, count: 16'd0};
    r_new  = r_base;
    if (cur.now > r_base.start) begin
      r_new.start = cur.now;
      r_new.count = 16'd0;
    end
    if (r_new.count != 16'hFFFF) r_new.count = r_new.count + 16'd1;
    unique case (cur.sel)
      pid_pkg::SEL_ICMP: r_limit = cfg.icmp_limit;
      pid_pkg::SEL_UDP:  r_limit = cfg.udp_limit;
      default:           r_limit = cfg.syn_limit;
    endcase
    s_base    = s_found ? s_ent : '{src: cur.src, start: cur.now, np: '0};
    s_diff    = cur.now - s_base.start;
    s_restart = (cur.now >= s_base.start) && (s_diff >= WIN);
    np_new    = (!p_found && s_np < P_MAX) ? s_np + NPW'(1) : s_np;
  end

  assign sweep_last = lag_v && (lag_idx == IW'(N - 1));
  assign ports_last = p_lag_v && (p_lag_k == s_np - NPW'(1));
  assign ports_go   = s_ok_now && !s_restart && (s_base.np != '0);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      pid_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          state_next = (cmd_in.need_rate || cmd_in.need_scan) ? pid_pkg::B_SWEEP
                                                              : pid_pkg::B_DONE;
        end
      end
      pid_pkg::B_SWEEP:  if (sweep_last) state_next = pid_pkg::B_UPDATE;
      pid_pkg::B_UPDATE: state_next = ports_go ? pid_pkg::B_PORTS : pid_pkg::B_WRITE;
      pid_pkg::B_PORTS:  if (ports_last) state_next = pid_pkg::B_WRITE;
      pid_pkg::B_WRITE:  state_next = pid_pkg::B_DONE;
      pid_pkg::B_DONE: begin
        res_push = 1'b1;
        if (!res_full) state_next = pid_pkg::B_IDLE;
      end
      default: state_next = pid_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pid_pkg::B_IDLE;
    else     state <= state_next;
  end

  // memories: registered reads, one write port each
  always_ff @(posedge clk) begin
    r_rd <= rmem[{cur.sel, cnt[IW-1:0]}];
    s_rd <= smem[cnt[IW-1:0]];
    p_rd <= pmem[{s_w_idx, k[PW-1:0]}];
    if (state == pid_pkg::B_UPDATE && r_ok) rmem[{cur.sel, r_sel_idx}] <= r_new;
    if (state == pid_pkg::B_WRITE && s_ok)
      smem[s_w_idx] <= '{src: cur.src, start: s_start, np: np_new};
    if (state == pid_pkg::B_WRITE && s_ok && !p_found && s_np < P_MAX)
      pmem[{s_w_idx, s_np[PW-1:0]}] <= cur.port;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) rvalid[i] <= '0;
      svalid  <= '0;
      lag_v   <= 1'b0;
      p_lag_v <= 1'b0;
    end else begin
      // read data lags the address, arriving in the next cycle
      lag_v   <= (state == pid_pkg::B_SWEEP) && (cnt < (IW+1)'(N));
      p_lag_v <= (state == pid_pkg::B_PORTS) && (k < s_np);
      unique case (state)
        pid_pkg::B_IDLE: begin
          cur     <= cmd_in;
          cnt     <= '0;
          r_found <= 1'b0;
          r_free  <= 1'b0;
          s_found <= 1'b0;
          s_free  <= 1'b0;
          res     <= '{syn: 1'b0, scan: 1'b0, kind: cmd_in.kind, icmp: 1'b0, udp: 1'b0,
                       any: 1'b0};
        end
        pid_pkg::B_SWEEP: begin
          if (cnt < (IW+1)'(N)) begin
            cnt     <= cnt + (IW+1)'(1);
            lag_idx <= cnt[IW-1:0];
          end
          if (lag_v) begin
            if (!r_found && rvalid[cur.sel][lag_idx] && r_rd.src == cur.src) begin
              r_found <= 1'b1;
              r_idx   <= lag_idx;
              r_ent   <= r_rd;
            end
            if (!r_free && !rvalid[cur.sel][lag_idx]) begin
              r_free <= 1'b1;
              r_fidx <= lag_idx;
            end
            if (!s_found && svalid[lag_idx] && s_rd.src == cur.src) begin
              s_found <= 1'b1;
              s_idx   <= lag_idx;
              s_ent   <= s_rd;
            end
            if (!s_free && !svalid[lag_idx]) begin
              s_free <= 1'b1;
              s_fidx <= lag_idx;
            end
          end
        end
        pid_pkg::B_UPDATE: begin
          if (r_ok) begin
            rvalid[cur.sel][r_sel_idx] <= 1'b1;
            unique case (cur.sel)
              pid_pkg::SEL_ICMP: res.icmp <= (r_new.count > r_limit);
              pid_pkg::SEL_UDP:  res.udp  <= (r_new.count > r_limit);
              default:           res.syn  <= (r_new.count > r_limit);
            endcase
          end
          s_ok    <= s_ok_now;
          s_w_idx <= s_sel_idx;
          s_start <= s_restart ? cur.now : s_base.start;
          s_np    <= s_restart ? '0 : s_base.np;
          k       <= '0;
          p_found <= 1'b0;
        end
        pid_pkg::B_PORTS: begin
          if (k < s_np) begin
            k       <= k + NPW'(1);
            p_lag_k <= k;
          end
          if (p_lag_v && p_rd == cur.port) p_found <= 1'b1;
        end
        pid_pkg::B_WRITE: begin
          if (s_ok) begin
            svalid[s_w_idx] <= 1'b1;
            res.scan <= ({{(16-NPW){1'b0}}, np_new} > cfg.scan_limit);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/packet_intrusion_detector_top.sv =====
// Packet intrusion detector: one result per packet header, queue-style ports.
// One packet in work at a time: a new packet is taken only after the result of
// the last one is queued. For packets that touch a table the work is the
// source-table sweep (one entry a cycle) and, when the port list is searched,
// the port-list search (one listed port a cycle). Synchronous reset clears all
// table valid bits at once and restores register defaults; no clearing pass.
// Depends on pid_pkg, pid_front, pid_fifo, pid_back.
`timescale 1ns / 1ps
module packet_intrusion_detector_top #(
  parameter int SOURCE_ENTRIES   = pid_pkg::SOURCE_ENTRIES_DEF,
  parameter int PORTS_PER_SOURCE = pid_pkg::PORTS_PER_SOURCE_DEF,
  parameter int SCAN_WINDOW_SEC  = pid_pkg::SCAN_WINDOW_SEC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  proto_num,
  input  logic [31:0] source_addr,
  input  logic [15:0] dest_port_num,
  input  logic [15:0] byte_length,
  input  logic [5:0]  flag_bits,
  input  logic        has_tcp_hdr,
  input  logic [31:0] stamp_sec,
  output logic        empty,
  input  logic        pop,
  output logic        syn_flood_hit,
  output logic        scan_hit,
  output logic [2:0]  anomaly_kind,
  output logic        icmp_flood_hit,
  output logic        udp_flood_hit,
  output logic        any_hit
);
  localparam int CW = $bits(pid_pkg::cmd_t);
  localparam int RW = $bits(pid_pkg::result_t);

  pid_pkg::cmd_t    f_cmd, b_cmd;
  pid_pkg::cfg_t    cfg;
  pid_pkg::result_t b_res, o_res;
  logic [CW-1:0]    cq_out;
  logic [RW-1:0]    rq_out;
  logic             cq_empty, cq_pop, rq_full, rq_push;

  pid_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .proto_num, .source_addr, .dest_port_num, .byte_length, .flag_bits,
    .has_tcp_hdr, .stamp_sec, .cmd(f_cmd), .cfg
  );

  pid_fifo #(.W(CW)) u_cmd_q (
    .clk, .rst, .push, .din(f_cmd), .full,
    .pop(cq_pop), .dout(cq_out), .empty(cq_empty)
  );

  assign b_cmd = pid_pkg::cmd_t'(cq_out);

  pid_back #(
    .SOURCE_ENTRIES(SOURCE_ENTRIES),
    .PORTS_PER_SOURCE(PORTS_PER_SOURCE),
    .SCAN_WINDOW_SEC(SCAN_WINDOW_SEC)
  ) u_back (
    .clk, .rst, .cfg, .cmd_in(b_cmd), .cmd_empty(cq_empty), .cmd_pop(cq_pop),
    .res_out(b_res), .res_full(rq_full), .res_push(rq_push)
  );

  pid_fifo #(.W(RW)) u_res_q (
    .clk, .rst, .push(rq_push), .din(b_res), .full(rq_full),
    .pop, .dout(rq_out), .empty
  );

  assign o_res          = pid_pkg::result_t'(rq_out);
  assign syn_flood_hit  = o_res.syn;
  assign scan_hit       = o_res.scan;
  assign anomaly_kind   = o_res.kind;
  assign icmp_flood_hit = o_res.icmp;
  assign udp_flood_hit  = o_res.udp;
  assign any_hit        = o_res.any;
endmodule
